// ===== hdl/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg
// Shared constants and transfer types of the earliest-deadline-first scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

	localparam int MAX_JOBS = 64;
	localparam int DAY_BITS = 16;

	localparam int CNT_W  = $clog2(MAX_JOBS + 1);
	localparam int DAY_W  = DAY_BITS;
	localparam int WORK_W = 16;
	localparam int ID_W   = 7;
	localparam int STAT_W = 3;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_CHECK = 2'd2;

	localparam logic [STAT_W-1:0] ST_ACCEPTED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
	localparam logic [STAT_W-1:0] ST_IDLE       = 3'd2;
	localparam logic [STAT_W-1:0] ST_RESERVED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_SERVED     = 3'd4;
	localparam logic [STAT_W-1:0] ST_MISSED     = 3'd5;
	localparam logic [STAT_W-1:0] ST_COMPLETE   = 3'd6;
	localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd7;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] job_deadline;
		logic [15:0] job_work;
		logic [6:0]  job_id;
		logic [15:0] day;
		logic        day_reserved;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] served_id;
		logic [6:0] pending_jobs;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

// ===== hdl/edf_ctrl.sv =====
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer: captures a request, fires one execute step, owns response valid.
// ----------------------------------------------------------------------------
module edf_ctrl import edf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic rsp_valid_q;

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && req_valid;
		cmd.execute = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	end

	assign req_stall = (state_q == S_EXEC);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.execute) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.execute) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> rsp_valid)
		else $error("execute step did not raise response valid");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !cmd.execute)
		else $error("pending response overwritten");
	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC))
		else $error("captured request not held for execution");

endmodule

// ===== hdl/edf_dp.sv =====
// ----------------------------------------------------------------------------
// edf_dp
// Datapath: request register, sorted shifting job store, miss flag, result.
// ----------------------------------------------------------------------------
module edf_dp import edf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_DEC  = 2'd2;
	localparam logic [1:0] OP_DROP = 2'd3;

	req_t req_q;
	rsp_t rsp_q;

	logic [DAY_W-1:0]  dl_q   [MAX_JOBS];
	logic [WORK_W-1:0] work_q [MAX_JOBS];
	logic [ID_W-1:0]   id_q   [MAX_JOBS];
	logic [CNT_W-1:0]  count_q;
	logic              miss_q;

	logic [DAY_W-1:0]  new_dl;
	logic [DAY_W-1:0]  today;
	logic [MAX_JOBS-1:0] lt;
	logic              full;
	logic              empty;
	logic              head_late;
	logic              head_last;
	logic [1:0]        op;
	logic              set_miss;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   served;
	logic [CNT_W-1:0]  count_d;

	// Hold the captured request until the execute step.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	assign new_dl    = DAY_W'(req_q.job_deadline);
	assign today     = DAY_W'(req_q.day);
	assign full      = (count_q == CNT_W'(MAX_JOBS));
	assign empty     = (count_q == '0);
	assign head_late = (dl_q[0] < today);
	assign head_last = (work_q[0] <= WORK_W'(1));

	// Entries ahead of the insertion point form a prefix of the valid cells.
	always_comb begin
		for (int k = 0; k < MAX_JOBS; k++) begin
			lt[k] = (CNT_W'(k) < count_q) && (dl_q[k] < new_dl);
		end
	end

	always_comb begin
		op       = OP_NONE;
		set_miss = 1'b0;
		served   = '0;
		status   = ST_INCOMPLETE;
		count_d  = count_q;
		case (req_q.req_type)
			REQ_ADD: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					status  = ST_ACCEPTED;
					op      = OP_INS;
					count_d = count_q + CNT_W'(1);
				end
			end
			REQ_TICK: begin
				if (miss_q) begin
					status = ST_MISSED;
				end else if (req_q.day_reserved) begin
					status = ST_RESERVED;
				end else if (empty) begin
					status = ST_IDLE;
				end else if (head_late) begin
					status   = ST_MISSED;
					set_miss = 1'b1;
				end else begin
					status = ST_SERVED;
					served = id_q[0];
					if (head_last) begin
						op      = OP_DROP;
						count_d = count_q - CNT_W'(1);
					end else begin
						op = OP_DEC;
					end
				end
			end
			default: begin
				status = (empty && !miss_q) ? ST_COMPLETE : ST_INCOMPLETE;
			end
		endcase
	end

	// Each cell looks only at its own neighbours: shift up, shift down or load.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			case (op)
				OP_INS: begin
					if (!lt[0]) begin
						dl_q[0]   <= new_dl;
						work_q[0] <= req_q.job_work;
						id_q[0]   <= req_q.job_id;
					end
					for (int k = 1; k < MAX_JOBS; k++) begin
						if (!lt[k]) begin
							if (lt[k-1]) begin
								dl_q[k]   <= new_dl;
								work_q[k] <= req_q.job_work;
								id_q[k]   <= req_q.job_id;
							end else begin
								dl_q[k]   <= dl_q[k-1];
								work_q[k] <= work_q[k-1];
								id_q[k]   <= id_q[k-1];
							end
						end
					end
				end
				OP_DEC: begin
					work_q[0] <= work_q[0] - WORK_W'(1);
				end
				OP_DROP: begin
					for (int k = 0; k < MAX_JOBS - 1; k++) begin
						dl_q[k]   <= dl_q[k+1];
						work_q[k] <= work_q[k+1];
						id_q[k]   <= id_q[k+1];
					end
				end
				default: begin
				end
			endcase
			rsp_q.status       <= status;
			rsp_q.served_id    <= served;
			rsp_q.pending_jobs <= 7'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			miss_q  <= 1'b0;
		end else if (cmd.execute) begin
			count_q <= count_d;
			if (set_miss) begin
				miss_q <= 1'b1;
			end
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_JOBS))
		else $error("job count beyond store depth");
	a_miss_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		miss_q |=> miss_q)
		else $error("miss flag cleared without reset");
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.execute |=> $stable(count_q))
		else $error("job count changed outside an execute step");

endmodule

// ===== hdl/edf_job_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// edf_job_scheduler_top
// Earliest-deadline-first job scheduler over a deadline-sorted job store.
// ----------------------------------------------------------------------------
//  channel | signals                   | direction | transfer when
//  --------+---------------------------+-----------+------------------------
//  req     | req_valid, req_stall, req | in        | req_valid && !req_stall
//  rsp     | rsp_valid, rsp_stall, rsp | out       | rsp_valid && !rsp_stall
//
//  Each request is captured, then executed against the store; the single
//  execute step of the sequencer sets the rate and waits on a stalled response.
//  Insertion costs the same at any fill: every store cell compares and shifts
//  in parallel. Reset clears the job count and the miss flag; store contents
//  are not cleared, as only cells below the count are ever read.
//  A stalled response holds; the next request is still taken and waits in
//  the request register until the response register is free.
// ----------------------------------------------------------------------------
module edf_job_scheduler_top import edf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;

	// Sequencer: advance capture and execute, drive both handshakes.
	edf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Datapath: hold the request, update the sorted store, build the result.
	edf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== tb/edf_schedule_checker.sv =====
// ----------------------------------------------------------------------------
// edf_schedule_checker
// Watches both channels of the job scheduler, predicts every response from
// its own copy of the deadline-sorted job store and compares field by field.
// ----------------------------------------------------------------------------
module edf_schedule_checker import edf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   awaited,
	output int   checked,
	output int   served_days,
	output int   missed_days,
	output int   full_adds
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DAY_W-1:0]  held_deadline [MAX_JOBS];
	logic [WORK_W-1:0] held_work     [MAX_JOBS];
	logic [ID_W-1:0]   held_id       [MAX_JOBS];
	int                held_count;
	logic              deadline_missed;
	rsp_t              due_rsp [$];

	int fails   = 0;
	int seen    = 0;
	int served  = 0;
	int missed  = 0;
	int refused = 0;

	// Apply one request to the job store and work out its response.
	task automatic schedule_step(input req_t r, output rsp_t o);
		int slot;
		int k;
		o = '0;
		case (r.req_type)
		REQ_ADD: begin
			if (held_count >= MAX_JOBS) begin
				o.status = ST_FULL;
			end else begin
				// newest job goes ahead of every equal or later deadline
				slot = 0;
				while (slot < held_count && held_deadline[slot] < r.job_deadline)
					slot++;
				for (k = held_count; k > slot; k--) begin
					held_deadline[k] = held_deadline[k-1];
					held_work[k]     = held_work[k-1];
					held_id[k]       = held_id[k-1];
				end
				held_deadline[slot] = r.job_deadline;
				held_work[slot]     = r.job_work;
				held_id[slot]       = r.job_id;
				held_count++;
				o.status = ST_ACCEPTED;
			end
		end
		REQ_TICK: begin
			if (deadline_missed) begin
				o.status = ST_MISSED;
			end else if (r.day_reserved) begin
				o.status = ST_RESERVED;
			end else if (held_count == 0) begin
				o.status = ST_IDLE;
			end else if (held_deadline[0] < r.day) begin
				deadline_missed = 1'b1;
				o.status = ST_MISSED;
			end else begin
				o.status    = ST_SERVED;
				o.served_id = held_id[0];
				if (held_work[0] <= 1) begin
					for (k = 1; k < held_count; k++) begin
						held_deadline[k-1] = held_deadline[k];
						held_work[k-1]     = held_work[k];
						held_id[k-1]       = held_id[k];
					end
					held_count--;
				end else begin
					held_work[0] = held_work[0] - 1'b1;
				end
			end
		end
		default: begin
			o.status = (held_count == 0 && !deadline_missed) ? ST_COMPLETE : ST_INCOMPLETE;
		end
		endcase
		o.pending_jobs = 7'(held_count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			held_count      = 0;
			deadline_missed = 1'b0;
			due_rsp.delete();
		end else begin
			if (req_valid && !req_stall) begin
				schedule_step(req, want);
				due_rsp = {due_rsp, want};
				if (want.status == ST_SERVED) served++;
				if (want.status == ST_MISSED) missed++;
				if (want.status == ST_FULL) refused++;
			end
			if (rsp_valid && !rsp_stall) begin
				seen++;
				if (due_rsp.size() == 0) begin
					$error("response with nothing outstanding: status %0d id %0d pending %0d",
						rsp.status, rsp.served_id, rsp.pending_jobs);
					fails++;
				end else begin
					want = due_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, rsp.status);
						fails++;
					end
					if (rsp.served_id !== want.served_id) begin
						$error("served_id mismatch: expected %0d, actual %0d",
							want.served_id, rsp.served_id);
						fails++;
					end
					if (rsp.pending_jobs !== want.pending_jobs) begin
						$error("pending_jobs mismatch: expected %0d, actual %0d",
							want.pending_jobs, rsp.pending_jobs);
						fails++;
					end
				end
			end
		end
		fail_count  <= fails;
		awaited     <= due_rsp.size();
		checked     <= seen;
		served_days <= served;
		missed_days <= missed;
		full_adds   <= refused;
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the earliest-deadline-first scheduler with a directed opening, a
// long run of random fill and drain bursts and a closing deadline miss, with
// random gaps on the request side and random back-pressure on responses.
// ----------------------------------------------------------------------------
module tb import edf_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// the unused request code, which the block treats as a final check
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// Random deadlines never fall below this and working days never reach
	// it, so no deadline passes until the closing part forces one.
	localparam int DEADLINE_FLOOR = 3000;
	localparam int RANDOM_ITEMS   = 2000;

	// windows with no idling: by transfer count on the request side,
	// by cycle count on the response side
	localparam int CALM_REQ_FIRST = 1200;
	localparam int CALM_REQ_LAST  = 1500;
	localparam int CALM_RSP_FIRST = 2500;
	localparam int CALM_RSP_LAST  = 4500;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int awaited;
	int checked;
	int served_days;
	int missed_days;
	int full_adds;

	int          sent     = 0;
	int          cycle_no = 0;
	logic [15:0] today;

	edf_job_scheduler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	edf_schedule_checker sched_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.awaited     (awaited),
		.checked     (checked),
		.served_days (served_days),
		.missed_days (missed_days),
		.full_adds   (full_adds)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Response back-pressure: stall with a probability of about 13 percent, except in
	// one long calm window where every response is taken at once.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= CALM_RSP_FIRST && cycle_no < CALM_RSP_LAST)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 99) < 13);
	end

	// Fill every field with random bits, so that the fields a request type
	// ignores still toggle; callers then set the fields that matter.
	function automatic req_t scrambled_request();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	// Offer one request and hold it until the block takes the transfer.
	// Idle cycles go in front of it at random, except in the calm window.
	task automatic send_request(input req_t r);
		if (!(sent >= CALM_REQ_FIRST && sent < CALM_REQ_LAST)) begin
			while ($urandom_range(0, 99) < 13) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= r;
		// hold valid and payload while the block stalls
		do @(posedge clk); while (req_stall);
		sent++;
	endtask

	task automatic add_job(input logic [6:0] id, input logic [15:0] dl,
			input logic [15:0] work);
		req_t r;
		r              = scrambled_request();
		r.req_type     = REQ_ADD;
		r.job_id       = id;
		r.job_deadline = dl;
		r.job_work     = work;
		send_request(r);
	endtask

	task automatic tick_day(input logic [15:0] d, input logic reserved_day);
		req_t r;
		r              = scrambled_request();
		r.req_type     = REQ_TICK;
		r.day          = d;
		r.day_reserved = reserved_day;
		send_request(r);
	endtask

	task automatic final_check(input logic [1:0] code);
		req_t r;
		r          = scrambled_request();
		r.req_type = code;
		send_request(r);
	endtask

	// Random traffic in bursts of a hundred requests: a filling burst is
	// mostly adds and pushes the store to full, a draining burst is mostly
	// working days and empties it again.
	task automatic random_requests(input int count);
		bit          filling;
		int          pick;
		logic [6:0]  id;
		logic [15:0] dl;
		logic [15:0] work;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0)
				filling = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < (filling ? 70 : 20)) begin
				// mostly valid ids, now and then any 7-bit value
				if ($urandom_range(0, 9) == 0)
					id = 7'($urandom_range(0, 127));
				else
					id = 7'($urandom_range(1, 64));
				// a third of the deadlines come from a small pool to force ties
				if ($urandom_range(0, 2) == 0)
					dl = 16'(DEADLINE_FLOOR + $urandom_range(0, 3) * 20000);
				else
					dl = 16'($urandom_range(DEADLINE_FLOOR, 65535));
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					work = '0;
				end else if (pick < 6) begin
					// long jobs sit near the back so they do not block the head
					work = 16'($urandom_range(0, 65535));
					dl   = 16'($urandom_range(60000, 65535));
				end else begin
					work = 16'($urandom_range(1, 6));
				end
				add_job(id, dl, work);
			end else if (pick < (filling ? 93 : 95)) begin
				if ($urandom_range(0, 3) == 0) begin
					tick_day(16'($urandom_range(0, 65535)), 1'b1);
				end else begin
					tick_day(today, 1'b0);
					if (today < DEADLINE_FLOOR - 1)
						today++;
				end
			end else begin
				final_check($urandom_range(0, 1) ? REQ_CHECK : REQ_SPARE);
			end
		end
	endtask

	initial begin
		req_valid <= 1'b0;
		req       <= '0;
		today      = 16'd13;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty store, reserved day, ties, zero work,
		// deadline met on the day itself, both final check codes.
		final_check(REQ_CHECK);
		tick_day(16'd1, 1'b0);
		tick_day(16'hFFFF, 1'b1);
		final_check(REQ_SPARE);
		add_job(7'd1, 16'd5, 16'd1);
		tick_day(16'd5, 1'b0);
		add_job(7'd127, 16'hFFFF, 16'hFFFF);
		add_job(7'd0, 16'hFFFF, 16'd0);
		add_job(7'd5, 16'd20, 16'd2);
		add_job(7'd6, 16'd20, 16'd1);
		add_job(7'd7, 16'd10, 16'd1);
		final_check(REQ_CHECK);
		tick_day(16'd6, 1'b0);
		tick_day(16'd7, 1'b1);
		tick_day(16'd8, 1'b0);
		tick_day(16'd9, 1'b0);
		tick_day(16'd10, 1'b0);
		tick_day(16'd11, 1'b0);
		tick_day(16'd12, 1'b0);

		random_requests(RANDOM_ITEMS);

		// Closing part: force a missed deadline, then check that the miss
		// sticks through reserved and working days while adds still go in.
		add_job(7'd9, 16'd1, 16'd3);
		tick_day(16'hFFFF, 1'b0);
		tick_day(16'd2, 1'b1);
		tick_day(16'd1, 1'b0);
		add_job(7'd64, 16'd40000, 16'd2);
		final_check(REQ_CHECK);
		final_check(REQ_SPARE);
		req_valid <= 1'b0;

		// drain: wait for every outstanding response, then let the bench settle
		do @(posedge clk); while (awaited != 0);
		repeat (8) @(posedge clk);

		$display("sent %0d requests, checked %0d responses", sent, checked);
		$display("days served %0d, days missed %0d, adds refused on a full store %0d",
			served_days, missed_days, full_adds);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

endmodule
